// File: hw/rtl/prf_pkg.sv
// ----------------------------------------------------------------------------
// Proximity risk fusion package
// Widths, level and exception codes, register indexes and fixed constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prf_pkg;

    localparam int POS_W      = 21;
    localparam int DIFF_W     = 22;
    localparam int SQ_W       = 44;
    localparam int ROOT_W     = 22;
    localparam int REM_W      = 24;
    localparam int ROOT_STEPS = 22;
    localparam int CNT_W      = 5;
    localparam int DIST_W     = 22;
    localparam int RNG_W      = 16;
    localparam int ACC_W      = 16;
    localparam int MEAS_W     = 23;
    localparam int LVL_W      = 2;
    localparam int EXC_W      = 3;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam int GRACE_MS       = 500;
    localparam int IGNORE_SENSORS = 0;

    localparam logic [LVL_W-1:0] LVL_SAFE      = 2'd0;
    localparam logic [LVL_W-1:0] LVL_CAUTION   = 2'd1;
    localparam logic [LVL_W-1:0] LVL_DANGER    = 2'd2;
    localparam logic [LVL_W-1:0] LVL_EMERGENCY = 2'd3;

    localparam logic [EXC_W-1:0] EXC_NONE        = 3'd0;
    localparam logic [EXC_W-1:0] EXC_SENSOR      = 3'd1;
    localparam logic [EXC_W-1:0] EXC_DEAD_RECKON = 3'd2;
    localparam logic [EXC_W-1:0] EXC_IMPACT      = 3'd3;
    localparam logic [EXC_W-1:0] EXC_UNCONFIRMED = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CAUTION       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DANGER        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EMERG_ENTER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EMERG_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RNG_CAUTION   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RNG_DANGER    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT   = 3'd7;

    localparam logic [DIST_W-1:0] RST_CAUTION       = 22'd3000;
    localparam logic [DIST_W-1:0] RST_DANGER        = 22'd1500;
    localparam logic [DIST_W-1:0] RST_EMERG_ENTER   = 22'd400;
    localparam logic [DIST_W-1:0] RST_EMERG_RELEASE = 22'd500;
    localparam logic [RNG_W-1:0]  RST_RNG_CAUTION   = 16'd1000;
    localparam logic [RNG_W-1:0]  RST_RNG_DANGER    = 16'd500;
    localparam logic [RNG_W-1:0]  RST_RADIUS        = 16'd0;
    localparam logic [ACC_W-1:0]  RST_ACCEL_LIMIT   = 16'd2000;

endpackage

`default_nettype wire

// File: hw/rtl/prf_in_if.sv
// ----------------------------------------------------------------------------
// Proximity risk fusion input channel
// Valid/ready channel that carries one frame item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface prf_in_if;

    logic                              valid;
    logic                              ready;
    logic                              vehicle_located;
    logic                              person_seen;
    logic signed [prf_pkg::POS_W-1:0]  vehicle_x;
    logic signed [prf_pkg::POS_W-1:0]  vehicle_y;
    logic signed [prf_pkg::POS_W-1:0]  person_x;
    logic signed [prf_pkg::POS_W-1:0]  person_y;
    logic                              range_valid;
    logic [prf_pkg::RNG_W-1:0]         range_distance;
    logic                              imu_valid;
    logic [prf_pkg::ACC_W-1:0]         accel_level;
    logic                              sensor_dead_reckoning;
    logic [prf_pkg::TIME_W-1:0]        frame_time;

    modport source (
        output valid, vehicle_located, person_seen, vehicle_x, vehicle_y,
               person_x, person_y, range_valid, range_distance, imu_valid,
               accel_level, sensor_dead_reckoning, frame_time,
        input  ready
    );

    modport sink (
        input  valid, vehicle_located, person_seen, vehicle_x, vehicle_y,
               person_x, person_y, range_valid, range_distance, imu_valid,
               accel_level, sensor_dead_reckoning, frame_time,
        output ready
    );

endinterface

`default_nettype wire

// File: hw/rtl/prf_out_if.sv
// ----------------------------------------------------------------------------
// Proximity risk fusion output channel
// Valid/ready channel that carries one graded result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface prf_out_if;

    logic                               valid;
    logic                               ready;
    logic signed [prf_pkg::MEAS_W-1:0]  measured_distance;
    logic [prf_pkg::LVL_W-1:0]          camera_level;
    logic [prf_pkg::LVL_W-1:0]          range_level;
    logic [prf_pkg::EXC_W-1:0]          exception_code;
    logic [prf_pkg::LVL_W-1:0]          final_level;

    modport source (
        output valid, measured_distance, camera_level, range_level,
               exception_code, final_level,
        input  ready
    );

    modport sink (
        input  valid, measured_distance, camera_level, range_level,
               exception_code, final_level,
        output ready
    );

endinterface

`default_nettype wire

// File: hw/rtl/proximity_risk_fusion.sv
// ----------------------------------------------------------------------------
// Proximity risk fusion
// Squares the position offsets on one shared multiplier, takes the integer
// square root one digit per cycle, then grades and fuses the risk levels.
// ----------------------------------------------------------------------------
// With both positions valid, the offsets are squared in S_MULX and S_MULY,
// the square root takes 22 steps and S_DONE grades the result; otherwise the
// item goes straight to S_DONE. A new item is accepted only in S_IDLE, once
// the previous item has been graded and loaded. The output register lets a new
// item enter while a result waits. Reset is synchronous and active low; it
// restores the register defaults and clears the latch and dead-reckoning state.
`timescale 1ns / 1ps
`default_nettype none

module proximity_risk_fusion (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [prf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [prf_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    prf_in_if.sink                              i_in,
    prf_out_if.source                           o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MULX = 3'd1;
    localparam logic [2:0] S_MULY = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam bit IGNORE = (prf_pkg::IGNORE_SENSORS != 0);
    localparam logic [prf_pkg::TIME_W-1:0] GRACE = prf_pkg::TIME_W'(prf_pkg::GRACE_MS);
    localparam logic [prf_pkg::CNT_W-1:0] LAST_STEP = prf_pkg::CNT_W'(prf_pkg::ROOT_STEPS - 1);

    function automatic logic [prf_pkg::LVL_W-1:0] f_max(
        input logic [prf_pkg::LVL_W-1:0] a,
        input logic [prf_pkg::LVL_W-1:0] b
    );
        return (a >= b) ? a : b;
    endfunction

    logic [2:0]                         r_state;
    logic [prf_pkg::DIST_W-1:0]         r_caution;
    logic [prf_pkg::DIST_W-1:0]         r_danger;
    logic [prf_pkg::DIST_W-1:0]         r_enter;
    logic [prf_pkg::DIST_W-1:0]         r_release;
    logic [prf_pkg::RNG_W-1:0]          r_rng_caution;
    logic [prf_pkg::RNG_W-1:0]          r_rng_danger;
    logic [prf_pkg::RNG_W-1:0]          r_radius;
    logic [prf_pkg::ACC_W-1:0]          r_accel_limit;

    logic                               r_located;
    logic                               r_person;
    logic                               r_rvalid;
    logic [prf_pkg::RNG_W-1:0]          r_rdist;
    logic                               r_ivalid;
    logic [prf_pkg::ACC_W-1:0]          r_accel;
    logic                               r_sdr;
    logic [prf_pkg::TIME_W-1:0]         r_time;
    logic signed [prf_pkg::DIFF_W-1:0]  r_dx;
    logic signed [prf_pkg::DIFF_W-1:0]  r_dy;

    logic [prf_pkg::SQ_W-1:0]           r_sq;
    logic [prf_pkg::REM_W-1:0]          r_rem;
    logic [prf_pkg::ROOT_W-1:0]         r_root;
    logic [prf_pkg::CNT_W-1:0]          r_cnt;

    logic                               r_latch;
    logic                               r_dr_held;
    logic [prf_pkg::TIME_W-1:0]         r_last_dr;

    logic                               r_out_valid;
    logic signed [prf_pkg::MEAS_W-1:0]  r_meas;
    logic [prf_pkg::LVL_W-1:0]          r_cam;
    logic [prf_pkg::LVL_W-1:0]          r_rng;
    logic [prf_pkg::EXC_W-1:0]          r_exc;
    logic [prf_pkg::LVL_W-1:0]          r_fin;

    logic                               in_accept;
    logic                               both_in;
    logic                               both;
    logic                               load_out;
    logic signed [prf_pkg::DIFF_W-1:0]  mul_op;
    logic signed [prf_pkg::SQ_W-1:0]    mul_res;
    logic [prf_pkg::REM_W+1:0]          rem_sh;
    logic [prf_pkg::REM_W+1:0]          trial;
    logic                               take;

    logic [prf_pkg::DIST_W-1:0]         eff;
    logic [prf_pkg::DIST_W-1:0]         radius_ext;
    logic [prf_pkg::TIME_W-1:0]         elapsed;
    logic                               raw_dr;
    logic                               held;
    logic                               n_latch;
    logic                               n_dr_held;
    logic [prf_pkg::TIME_W-1:0]         n_last_dr;
    logic signed [prf_pkg::MEAS_W-1:0]  n_meas;
    logic [prf_pkg::LVL_W-1:0]          n_cam;
    logic [prf_pkg::LVL_W-1:0]          n_rng;
    logic [prf_pkg::EXC_W-1:0]          n_exc;
    logic [prf_pkg::LVL_W-1:0]          n_fin;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_accept  = i_in.valid && i_in.ready;
    assign both_in    = i_in.vehicle_located && i_in.person_seen;
    assign both       = r_located && r_person;
    assign load_out   = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    assign o_out.valid             = r_out_valid;
    assign o_out.measured_distance = r_meas;
    assign o_out.camera_level      = r_cam;
    assign o_out.range_level       = r_rng;
    assign o_out.exception_code    = r_exc;
    assign o_out.final_level       = r_fin;

    // Shared multiplier: squares dx, then dy.
    assign mul_op  = (r_state == S_MULX) ? r_dx : r_dy;
    assign mul_res = mul_op * mul_op;

    // One restoring square root digit per cycle.
    assign rem_sh = {r_rem, r_sq[prf_pkg::SQ_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_comb begin
        radius_ext = prf_pkg::DIST_W'(r_radius);
        eff        = (r_root > radius_ext) ? (r_root - radius_ext) : '0;
        elapsed    = r_time - r_last_dr;
        raw_dr     = 1'b0;
        held       = 1'b0;
        n_latch    = r_latch;
        n_dr_held  = r_dr_held;
        n_last_dr  = r_last_dr;
        n_cam      = prf_pkg::LVL_SAFE;
        n_rng      = prf_pkg::LVL_SAFE;
        n_exc      = prf_pkg::EXC_NONE;
        n_meas     = both ? prf_pkg::MEAS_W'({1'b0, r_root}) : '1;

        if (both) begin
            if (r_latch) begin
                if (eff <= r_release) begin
                    n_cam = prf_pkg::LVL_EMERGENCY;
                end else begin
                    n_latch = 1'b0;
                end
            end else if (eff <= r_enter) begin
                n_latch = 1'b1;
                n_cam   = prf_pkg::LVL_EMERGENCY;
            end
            if (n_cam != prf_pkg::LVL_EMERGENCY) begin
                priority if (eff <= r_danger) begin
                    n_cam = prf_pkg::LVL_DANGER;
                end else if (eff <= r_caution) begin
                    n_cam = prf_pkg::LVL_CAUTION;
                end else begin
                    n_cam = prf_pkg::LVL_SAFE;
                end
            end
        end else begin
            n_latch = 1'b0;
        end

        if (!IGNORE && r_rvalid) begin
            priority if (r_rdist <= r_rng_danger) begin
                n_rng = prf_pkg::LVL_DANGER;
            end else if (r_rdist <= r_rng_caution) begin
                n_rng = prf_pkg::LVL_CAUTION;
            end else begin
                n_rng = prf_pkg::LVL_SAFE;
            end
        end

        priority if (!IGNORE && (r_accel >= r_accel_limit)) begin
            n_exc = prf_pkg::EXC_IMPACT;
        end else if (!IGNORE && (!r_ivalid || !r_rvalid)) begin
            n_exc = prf_pkg::EXC_SENSOR;
        end else begin
            raw_dr = !r_located || (!IGNORE && r_sdr);
            if (raw_dr) begin
                n_dr_held = 1'b1;
                n_last_dr = r_time;
                n_exc     = prf_pkg::EXC_DEAD_RECKON;
                held      = 1'b1;
            end else if (r_dr_held) begin
                if (elapsed < GRACE) begin
                    n_exc = prf_pkg::EXC_DEAD_RECKON;
                    held  = 1'b1;
                end else begin
                    n_dr_held = 1'b0;
                end
            end
            if (!held) begin
                if (!IGNORE && !r_person && (n_rng != prf_pkg::LVL_SAFE)) begin
                    n_exc = prf_pkg::EXC_UNCONFIRMED;
                end else begin
                    n_exc = prf_pkg::EXC_NONE;
                end
            end
        end

        n_fin = f_max(n_cam, n_rng);
        if (n_exc == prf_pkg::EXC_IMPACT) begin
            n_fin = f_max(n_fin, prf_pkg::LVL_DANGER);
        end else if ((n_exc == prf_pkg::EXC_SENSOR) || (n_exc == prf_pkg::EXC_DEAD_RECKON)) begin
            n_fin = f_max(n_fin, prf_pkg::LVL_CAUTION);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caution     <= prf_pkg::RST_CAUTION;
            r_danger      <= prf_pkg::RST_DANGER;
            r_enter       <= prf_pkg::RST_EMERG_ENTER;
            r_release     <= prf_pkg::RST_EMERG_RELEASE;
            r_rng_caution <= prf_pkg::RST_RNG_CAUTION;
            r_rng_danger  <= prf_pkg::RST_RNG_DANGER;
            r_radius      <= prf_pkg::RST_RADIUS;
            r_accel_limit <= prf_pkg::RST_ACCEL_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                prf_pkg::REG_CAUTION:       r_caution     <= i_cfg_wdata;
                prf_pkg::REG_DANGER:        r_danger      <= i_cfg_wdata;
                prf_pkg::REG_EMERG_ENTER:   r_enter       <= i_cfg_wdata;
                prf_pkg::REG_EMERG_RELEASE: r_release     <= i_cfg_wdata;
                prf_pkg::REG_RNG_CAUTION:   r_rng_caution <= i_cfg_wdata[prf_pkg::RNG_W-1:0];
                prf_pkg::REG_RNG_DANGER:    r_rng_danger  <= i_cfg_wdata[prf_pkg::RNG_W-1:0];
                prf_pkg::REG_RADIUS:        r_radius      <= i_cfg_wdata[prf_pkg::RNG_W-1:0];
                prf_pkg::REG_ACCEL_LIMIT:   r_accel_limit <= i_cfg_wdata[prf_pkg::ACC_W-1:0];
                default:                    r_caution     <= r_caution;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_latch     <= 1'b0;
            r_dr_held   <= 1'b0;
            r_last_dr   <= '0;
        end else begin
            r_out_valid <= load_out || (r_out_valid && !o_out.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= both_in ? S_MULX : S_DONE;
                    end
                end
                S_MULX: begin
                    r_state <= S_MULY;
                end
                S_MULY: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_cnt == LAST_STEP) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state     <= S_IDLE;
                        r_latch     <= n_latch;
                        r_dr_held   <= n_dr_held;
                        r_last_dr   <= n_last_dr;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_located <= i_in.vehicle_located;
            r_person  <= i_in.person_seen;
            r_rvalid  <= i_in.range_valid;
            r_rdist   <= i_in.range_distance;
            r_ivalid  <= i_in.imu_valid;
            r_accel   <= i_in.accel_level;
            r_sdr     <= i_in.sensor_dead_reckoning;
            r_time    <= i_in.frame_time;
            r_dx      <= prf_pkg::DIFF_W'(i_in.vehicle_x) - prf_pkg::DIFF_W'(i_in.person_x);
            r_dy      <= prf_pkg::DIFF_W'(i_in.vehicle_y) - prf_pkg::DIFF_W'(i_in.person_y);
        end
        unique case (r_state)
            S_MULX: begin
                r_sq <= prf_pkg::SQ_W'(mul_res);
            end
            S_MULY: begin
                r_sq   <= r_sq + prf_pkg::SQ_W'(mul_res);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            S_ROOT: begin
                r_sq   <= {r_sq[prf_pkg::SQ_W-3:0], 2'b00};
                r_cnt  <= r_cnt + 1'b1;
                r_rem  <= take ? prf_pkg::REM_W'(rem_sh - trial) : prf_pkg::REM_W'(rem_sh);
                r_root <= {r_root[prf_pkg::ROOT_W-2:0], take};
            end
            default: begin
                r_sq <= r_sq;
            end
        endcase
        if (load_out) begin
            r_meas <= n_meas;
            r_cam  <= n_cam;
            r_rng  <= n_rng;
            r_exc  <= n_exc;
            r_fin  <= n_fin;
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("Sequencer stayed idle after an item was accepted.");

    a_root_steps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> (r_cnt <= LAST_STEP))
        else $error("Square root step count ran past the last digit.");

    a_emergency_measured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_cam == prf_pkg::LVL_EMERGENCY)) |-> (r_meas != '1))
        else $error("Emergency level given without a measured distance.");

    a_final_not_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_fin >= r_cam) && (r_fin >= r_rng)))
        else $error("Fused level lies below a component level.");
`endif

endmodule

`default_nettype wire
